@@ rtl/psf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package psf_pkg;
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_CLOSE = 2'd1;
    localparam logic [1:0] FUNC_SPAN  = 2'd2;
    localparam int FRAC_BITS = 16;
    localparam int EDGE_W    = 27;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] x;
        logic [8:0] y;
        logic [7:0] color;
    } t_cmd;
endpackage
`default_nettype wire

@@ rtl/polygon_scanline_filler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Scanline polygon filler. Vertices (func 0) load one per cycle while the engine is idle
// and no span waits; a close (func 1) walks every non-flat edge: an edge-fetch state reads
// the edge, a serial divider forms the 11.16 slope one quotient bit per cycle, then one
// row per cycle is written to the left or right edge memory. A span request (func 2)
// reads both edge memories and, while rows remain, returns one span through the ST_RD
// and ST_OUT states. A two-beat command queue sits in front of the engine so the input
// side keeps taking beats while the engine is busy, until the queue is full.
module polygon_scanline_filler
    import psf_pkg::*;
#(
    parameter int MAX_VERTICES = 8,
    parameter int SCREEN_ROWS  = 512
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_func,
    input  wire  [9:0]  i_vertex_x,
    input  wire  [8:0]  i_vertex_y,
    input  wire  [7:0]  i_fill_color,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [8:0]  o_span_row,
    output logic signed [10:0] o_span_start,
    output logic signed [11:0] o_span_length,
    output logic [7:0]  o_span_color,
    output logic        o_span_last
);
    logic w_qv, w_qr;
    t_cmd w_cmd;

    psf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y),
        .i_fill_color(i_fill_color), .o_q_valid(w_qv), .i_q_ready(w_qr),
        .o_q_cmd(w_cmd)
    );

    psf_back #(.MAX_VERTICES(MAX_VERTICES), .SCREEN_ROWS(SCREEN_ROWS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_ready(w_qr),
        .i_q_cmd(w_cmd), .o_valid(o_valid), .i_ready(i_ready),
        .o_row(o_span_row), .o_start(o_span_start), .o_length(o_span_length),
        .o_color(o_span_color), .o_last(o_span_last)
    );
endmodule
`default_nettype wire

@@ rtl/psf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psf_front
    import psf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [1:0] i_func,
    input  wire  [9:0] i_vertex_x,
    input  wire  [8:0] i_vertex_y,
    input  wire  [7:0] i_fill_color,
    output logic       o_q_valid,
    input  wire        i_q_ready,
    output t_cmd       o_q_cmd
);
    // Two-entry queue; unused function codes are dropped here.
    t_cmd       r_mem [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       w_push, w_pop, w_acc;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_acc     = i_valid && o_ready;
    assign w_push    = w_acc && (i_func != 2'd3);
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_mem[r_wp] <= '{func: i_func, x: i_vertex_x, y: i_vertex_y,
                             color: i_fill_color};
        end
    end
endmodule
`default_nettype wire

@@ rtl/psf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psf_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [10:0] i_dx,
    input  wire  [9:0]  i_dy,
    output logic        o_done,
    output logic [26:0] o_q
);
    // Restoring divide, one quotient bit per cycle, of |dx|<<16 by |dy|.
    logic [26:0] r_num, n_num;
    logic [9:0]  r_den;
    logic [9:0]  r_rem;
    logic [10:0] w_trial;
    logic [4:0]  r_cnt;
    logic        r_busy, r_neg;
    logic [10:0] w_adx;
    logic [9:0]  w_ady;

    assign w_adx   = i_dx[10] ? -i_dx : i_dx;
    assign w_ady   = i_dy[9] ? -i_dy : i_dy;
    assign w_trial = {r_rem, r_num[26]} - {1'b0, r_den};
    assign n_num   = {r_num[25:0], ~w_trial[10]};
    assign o_q     = r_neg ? -r_num : r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd26;
                r_num  <= {w_adx, 16'd0};
                r_rem  <= '0;
                r_den  <= w_ady;
                r_neg  <= i_dx[10] ^ i_dy[9];
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= w_trial[10] ? {r_rem[8:0], r_num[26]} : w_trial[9:0];
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/psf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psf_back
    import psf_pkg::*;
#(
    parameter int MAX_VERTICES = 8,
    parameter int SCREEN_ROWS  = 512
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_q_valid,
    output logic        o_q_ready,
    input  t_cmd        i_q_cmd,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [8:0]  o_row,
    output logic [10:0] o_start,
    output logic [11:0] o_length,
    output logic [7:0]  o_color,
    output logic        o_last
);
    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int VI = $clog2(MAX_VERTICES);
    // Vertex rows are 9 bits, so no row past 511 is ever written or read.
    localparam int ROWS_USED = (SCREEN_ROWS < 512) ? SCREEN_ROWS : 512;
    localparam int RW = $clog2(ROWS_USED);

    localparam logic [2:0] ST_IDLE = 3'd0, ST_EDGE = 3'd1, ST_DIV = 3'd2,
                           ST_WALK = 3'd3, ST_RD = 3'd4, ST_OUT = 3'd5;

    logic [2:0]    r_st;
    logic [18:0]   r_vtx [MAX_VERTICES];
    logic [VW-1:0] r_vcnt;
    logic [VI-1:0] r_ei;
    logic [EDGE_W-1:0] r_lmem [ROWS_USED];
    logic [EDGE_W-1:0] r_rmem [ROWS_USED];
    logic [EDGE_W-1:0] r_ld, r_rd;
    logic [9:0]    r_top, r_bot, r_cur;
    logic [7:0]    r_color;
    logic          r_any;
    logic [EDGE_W-1:0] r_x, r_step;
    logic [9:0]    r_j, r_jend;
    logic          r_down;
    logic [9:0]    r_x1, r_x2, r_y1, r_y2;
    logic          w_dstart, w_ddone;
    logic [EDGE_W-1:0] w_q;
    logic [VI-1:0] w_nx;
    logic [18:0]   w_a, w_b;
    logic [10:0]   w_l, w_r;

    assign w_nx = ({1'b0, r_ei} + 1'b1 < (VI+1)'(r_vcnt)) ? r_ei + 1'b1 : '0;
    assign w_a  = r_vtx[r_ei];
    assign w_b  = r_vtx[w_nx];
    assign w_dstart = (r_st == ST_EDGE) && (w_a[18:10] != w_b[18:10]);

    psf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_dx   ({1'b0, w_b[9:0]} - {1'b0, w_a[9:0]}),
        .i_dy   ({1'b0, w_b[18:10]} - {1'b0, w_a[18:10]}),
        .o_done (w_ddone),
        .o_q    (w_q)
    );

    assign o_q_ready = (r_st == ST_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (r_st == ST_WALK && r_j < 10'(ROWS_USED)) begin
            if (r_down) r_lmem[r_j[RW-1:0]] <= r_x;
            else        r_rmem[r_j[RW-1:0]] <= r_x;
        end
        r_ld <= r_lmem[r_cur[RW-1:0]];
        r_rd <= r_rmem[r_cur[RW-1:0]];
        if (o_q_ready && i_q_valid && i_q_cmd.func == FUNC_ADD
            && r_vcnt < VW'(MAX_VERTICES)) begin
            r_vtx[r_vcnt[VI-1:0]] <= {i_q_cmd.y, i_q_cmd.x};
        end
    end

    assign w_l = (r_cur < 10'(ROWS_USED)) ? r_ld[26:16] : '0;
    assign w_r = (r_cur < 10'(ROWS_USED)) ? r_rd[26:16] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_vcnt <= '0; r_top <= '0; r_bot <= '0;
            r_cur <= '0; r_color <= '0; o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (o_q_ready && i_q_valid) begin
                        unique case (i_q_cmd.func)
                            FUNC_ADD: if (r_vcnt < VW'(MAX_VERTICES))
                                r_vcnt <= r_vcnt + 1'b1;
                            FUNC_CLOSE: begin
                                r_color <= i_q_cmd.color;
                                r_ei <= '0;
                                r_any <= 1'b0;
                                r_top <= '0; r_bot <= '0;
                                if (r_vcnt == '0) begin
                                    r_cur <= '0;
                                end else begin
                                    r_st <= ST_EDGE;
                                end
                            end
                            FUNC_SPAN: if (r_cur < r_bot) r_st <= ST_RD;
                            default: ;
                        endcase
                    end
                end
                ST_EDGE: begin
                    r_x1 <= w_a[9:0]; r_y1 <= {1'b0, w_a[18:10]};
                    r_x2 <= w_b[9:0]; r_y2 <= {1'b0, w_b[18:10]};
                    if (w_dstart) begin
                        if (!r_any || {1'b0, w_a[18:10]} < r_top)
                            r_top <= {1'b0, w_a[18:10]};
                        if (!r_any || {1'b0, w_a[18:10]} > r_bot)
                            r_bot <= {1'b0, w_a[18:10]};
                        r_any <= 1'b1;
                        r_st <= ST_DIV;
                    end else if ({1'b0, r_ei} + 1'b1 >= (VI+1)'(r_vcnt)) begin
                        r_st <= ST_IDLE; r_vcnt <= '0;
                        r_cur <= r_any ? r_top : '0;
                    end else begin
                        r_ei <= r_ei + 1'b1;
                    end
                end
                ST_DIV: if (w_ddone) begin
                    r_step <= w_q;
                    r_down <= r_y2 > r_y1;
                    r_j    <= (r_y2 > r_y1) ? r_y1 : r_y2;
                    r_jend <= (r_y2 > r_y1) ? r_y2 : r_y1;
                    r_x    <= (r_y2 > r_y1) ? {1'b0, r_x1, 16'd0}
                                            : {1'b0, r_x2, 16'd0};
                    r_st   <= ST_WALK;
                end
                ST_WALK: begin
                    r_x <= r_x + r_step;
                    r_j <= r_j + 1'b1;
                    if (r_j == r_jend) begin
                        if ({1'b0, r_ei} + 1'b1 >= (VI+1)'(r_vcnt)) begin
                            r_st <= ST_IDLE; r_vcnt <= '0;
                            r_cur <= r_top;
                        end else begin
                            r_ei <= r_ei + 1'b1;
                            r_st <= ST_EDGE;
                        end
                    end
                end
                ST_RD: r_st <= ST_OUT;
                ST_OUT: begin
                    o_valid  <= 1'b1;
                    o_row    <= r_cur[8:0];
                    o_start  <= w_l;
                    o_length <= {w_r[10], w_r} - {w_l[10], w_l};
                    o_color  <= r_color;
                    o_last   <= (r_cur + 1'b1 == r_bot);
                    r_cur    <= r_cur + 1'b1;
                    r_st     <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
